FILE: rtl/core/cfs_pkg.sv
// Shared types and constants of the correlation fitness scorer.
`timescale 1ns / 1ps
package cfs_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int SUMX_W      = 26;
	localparam int SUMXX_W     = 41;
	localparam int SUMXY_W     = 42;
	localparam int CNT_W       = 11;
	localparam int MAX_SAMPLES = 1024;
	localparam int FIT_W       = 32;
	localparam int CORR_W      = 16;

	localparam logic [FIT_W-1:0] FIT_DEGEN = 32'h0004_0000;
	localparam logic [14:0]      R_ONE     = 15'd16384;
	localparam logic [20:0]      QCAP      = 21'h10_0000;
	localparam logic [9:0]       DEN_POS   = 10'd1000;
	localparam logic [9:0]       DEN_NEG   = 10'd10;
	localparam int               SQRT_STEPS = 32;
	localparam int               DIV1_BASE  = 78;
	localparam int               DIV2_STEPS = 128;

	typedef enum logic [3:0] {
		S_ACC,
		S_MUL_START,
		S_MUL_WAIT,
		S_CHECK,
		S_NORM,
		S_SQRT,
		S_DIV1,
		S_DIV2,
		S_FINISH
	} ctl_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_MUL_START,
		OP_CHECK,
		OP_NORM,
		OP_SQRT_INIT,
		OP_SQRT_STEP,
		OP_DIV1_STEP,
		OP_DIV2_STEP,
		OP_FINISH
	} dp_op_t;

	// Multiply steps in the order the controller issues them.
	typedef enum logic [3:0] {
		MS_NSXX,
		MS_SXSX,
		MS_NSYY,
		MS_SYSY,
		MS_NSXY,
		MS_SXSY,
		MS_D,
		MS_N2,
		MS_N4,
		MS_P,
		MS_DA,
		MS_DV
	} mul_sel_t;

	typedef struct packed {
		dp_op_t   op;
		mul_sel_t sel;
	} dp_cmd_t;

	typedef struct packed {
		logic       mul_done;
		logic       degen;
		logic       norm_done;
		logic [6:0] half_shift;
		logic       out_busy;
	} dp_stat_t;

endpackage

FILE: rtl/core/cfs_in_if.sv
// Sample channel interface: valid, ready and one sample pair.
`timescale 1ns / 1ps
interface cfs_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [cfs_pkg::SAMPLE_W-1:0]  x_sample;
	logic signed [cfs_pkg::SAMPLE_W-1:0]  y_sample;
	logic                                 last;

	modport source (output valid, output x_sample, output y_sample, output last, input ready);
	modport sink (input valid, input x_sample, input y_sample, input last, output ready);
endinterface

FILE: rtl/core/cfs_out_if.sv
// Result channel interface: valid, ready and one score.
`timescale 1ns / 1ps
interface cfs_out_if;
	logic                               valid;
	logic                               ready;
	logic [cfs_pkg::FIT_W-1:0]          fitness;
	logic signed [cfs_pkg::CORR_W-1:0]  correlation;
	logic                               degenerate;
	logic                               saturated;

	modport source (output valid, output fitness, output correlation, output degenerate,
		output saturated, input ready);
	modport sink (input valid, input fitness, input correlation, input degenerate,
		input saturated, output ready);
endinterface

FILE: rtl/core/cfs_mul.sv
// Shift-and-add 64 by 64 multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module cfs_mul (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [63:0]   op_a,
	input  logic [63:0]   op_b,
	output logic          done,
	output logic [127:0]  product
);
	logic [127:0] ma_q;
	logic [63:0]  mb_q;
	logic [127:0] acc_q;
	logic [5:0]   cnt_q;
	logic         busy_q;
	logic         done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= {64'd0, op_a};
			mb_q  <= op_b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (mb_q[0]) begin
				acc_q <= acc_q + ma_q;
			end
			ma_q <= ma_q << 1;
			mb_q <= mb_q >> 1;
		end
	end

	assign done    = done_q;
	assign product = acc_q;
endmodule

FILE: rtl/core/cfs_datapath.sv
// Datapath: running sums, shared multiplier, normalizer, square roots, dividers, result register.
`timescale 1ns / 1ps
module cfs_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cfs_pkg::dp_cmd_t                    cmd,
	output cfs_pkg::dp_stat_t                   stat,
	input  logic                                in_accept,
	input  logic signed [cfs_pkg::SAMPLE_W-1:0] x_sample,
	input  logic signed [cfs_pkg::SAMPLE_W-1:0] y_sample,
	input  logic                                out_accept,
	output logic                                out_valid,
	output logic [cfs_pkg::FIT_W-1:0]           fitness,
	output logic signed [cfs_pkg::CORR_W-1:0]   correlation,
	output logic                                degenerate,
	output logic                                saturated
);
	import cfs_pkg::*;

	logic signed [SUMX_W-1:0]  sum_x_q, sum_y_q;
	logic [SUMXX_W-1:0]        sum_xx_q, sum_yy_q;
	logic signed [SUMXY_W-1:0] sum_xy_q;
	logic [CNT_W-1:0]          count_q;
	logic signed [31:0]        xx, yy, xy;

	logic signed [63:0] tmp_q, a_q, b_q, c_q;
	logic [63:0]        d_q;
	logic [57:0]        p_q;
	logic [127:0]       dv_q;
	logic               mul_neg_q;

	logic [63:0] na_q, nb_q;
	logic [5:0]  ka_q, kb_q;
	logic [63:0] va_q, vb_q, ra_q, rb_q, bit_q;
	logic [63:0] cm_q, rem1_q;
	logic [20:0] q1_q;
	logic [127:0] num_q, rem2_q;
	logic [FIT_W-1:0] fq_q;
	logic             sat_q;

	logic             out_valid_q;
	logic [FIT_W-1:0] fit_q;
	logic signed [CORR_W-1:0] corr_q;
	logic             deg_q, satf_q;

	logic [SUMX_W-1:0]  abs_x, abs_y;
	logic [SUMXY_W-1:0] abs_xy;
	logic [63:0]        mul_a, mul_b;
	logic               mul_neg;
	logic               mul_done;
	logic [127:0]       mul_product;
	logic [63:0]        prod_lo;
	logic signed [63:0] prod_s;

	logic [63:0] sa_try, sb_try;
	logic        sa_ge, sb_ge;
	logic [63:0] rem1_sh;
	logic        ge1;
	logic [21:0] q1_next;
	logic [21:0] q1_inc;
	logic [14:0] rmag, m;
	logic [18:0] m9;
	logic [9:0]  den;
	logic [127:0] rem2_sh;
	logic         ge2;
	logic [32:0]  fq_next;
	logic         is_degen;
	logic [6:0]   half;

	assign xx = x_sample * x_sample;
	assign yy = y_sample * y_sample;
	assign xy = x_sample * y_sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			sum_xx_q <= '0;
			sum_yy_q <= '0;
			sum_xy_q <= '0;
			count_q  <= '0;
		end else if (cmd.op == OP_FINISH) begin
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			sum_xx_q <= '0;
			sum_yy_q <= '0;
			sum_xy_q <= '0;
			count_q  <= '0;
		end else if (in_accept && (count_q < CNT_W'(MAX_SAMPLES))) begin
			sum_x_q  <= sum_x_q + SUMX_W'(x_sample);
			sum_y_q  <= sum_y_q + SUMX_W'(y_sample);
			sum_xx_q <= sum_xx_q + SUMXX_W'($unsigned(xx));
			sum_yy_q <= sum_yy_q + SUMXX_W'($unsigned(yy));
			sum_xy_q <= sum_xy_q + SUMXY_W'(xy);
			count_q  <= count_q + CNT_W'(1);
		end
	end

	assign abs_x  = sum_x_q[SUMX_W-1] ? $unsigned(-sum_x_q) : $unsigned(sum_x_q);
	assign abs_y  = sum_y_q[SUMX_W-1] ? $unsigned(-sum_y_q) : $unsigned(sum_y_q);
	assign abs_xy = sum_xy_q[SUMXY_W-1] ? $unsigned(-sum_xy_q) : $unsigned(sum_xy_q);

	// Correlation magnitude with rounding, then the fitness factor.
	assign q1_inc = 22'(q1_q) + 22'd1;
	assign rmag   = (q1_inc[21:1] > 21'(R_ONE)) ? R_ONE : q1_inc[15:1];
	assign m      = R_ONE - rmag;
	assign m9     = {1'b0, m, 3'b000} + 19'(m);
	assign den    = (c_q > 64'sd0) ? DEN_POS : DEN_NEG;

	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		mul_neg = 1'b0;
		unique case (cmd.sel)
			MS_NSXX: begin
				mul_a = 64'(count_q);
				mul_b = 64'(sum_xx_q);
			end
			MS_SXSX: begin
				mul_a = 64'(abs_x);
				mul_b = 64'(abs_x);
			end
			MS_NSYY: begin
				mul_a = 64'(count_q);
				mul_b = 64'(sum_yy_q);
			end
			MS_SYSY: begin
				mul_a = 64'(abs_y);
				mul_b = 64'(abs_y);
			end
			MS_NSXY: begin
				mul_a   = 64'(count_q);
				mul_b   = 64'(abs_xy);
				mul_neg = sum_xy_q[SUMXY_W-1];
			end
			MS_SXSY: begin
				mul_a   = 64'(abs_x);
				mul_b   = 64'(abs_y);
				mul_neg = sum_x_q[SUMX_W-1] ^ sum_y_q[SUMX_W-1];
			end
			MS_D: begin
				mul_a = ra_q;
				mul_b = rb_q;
			end
			MS_N2: begin
				mul_a = 64'(count_q);
				mul_b = 64'(count_q);
			end
			MS_N4: begin
				mul_a = $unsigned(tmp_q);
				mul_b = $unsigned(tmp_q);
			end
			MS_P: begin
				mul_a = $unsigned(tmp_q);
				mul_b = 64'(m9);
			end
			MS_DA: begin
				mul_a = 64'(den);
				mul_b = $unsigned(a_q);
			end
			MS_DV: begin
				mul_a = $unsigned(tmp_q);
				mul_b = $unsigned(b_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	cfs_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.op == OP_MUL_START),
		.op_a    (mul_a),
		.op_b    (mul_b),
		.done    (mul_done),
		.product (mul_product)
	);

	assign prod_lo = mul_product[63:0];
	assign prod_s  = mul_neg_q ? -$signed(prod_lo) : $signed(prod_lo);

	// One step of the digit-by-digit square root on both deviation sums.
	assign sa_try = ra_q + bit_q;
	assign sb_try = rb_q + bit_q;
	assign sa_ge  = va_q >= sa_try;
	assign sb_ge  = vb_q >= sb_try;

	// One step of the correlation divider.
	assign rem1_sh = {rem1_q[62:0], cm_q[62]};
	assign ge1     = rem1_sh >= d_q;
	assign q1_next = {q1_q, ge1};

	// One step of the fitness divider.
	assign rem2_sh = {rem2_q[126:0], num_q[127]};
	assign ge2     = rem2_sh >= dv_q;
	assign fq_next = {fq_q, ge2};

	assign is_degen = (a_q <= 64'sd0) || (b_q <= 64'sd0);
	assign half     = 7'((7'(ka_q) + 7'(kb_q)) >> 1);

	always_ff @(posedge clk) begin
		if (cmd.op == OP_MUL_START) begin
			mul_neg_q <= mul_neg;
		end
		if (mul_done) begin
			unique case (cmd.sel)
				MS_NSXX, MS_NSYY, MS_N2, MS_N4, MS_DA: tmp_q <= $signed(prod_lo);
				MS_SXSX: a_q <= tmp_q - $signed(prod_lo);
				MS_SYSY: b_q <= tmp_q - $signed(prod_lo);
				MS_NSXY: tmp_q <= prod_s;
				MS_SXSY: c_q <= tmp_q - prod_s;
				MS_D: begin
					d_q    <= prod_lo;
					cm_q   <= c_q[63] ? $unsigned(-c_q) : $unsigned(c_q);
					rem1_q <= '0;
					q1_q   <= '0;
				end
				MS_P: p_q <= prod_lo[57:0];
				MS_DV: begin
					dv_q   <= mul_product;
					num_q  <= {20'd0, p_q, 50'd0};
					rem2_q <= '0;
					fq_q   <= '0;
					sat_q  <= 1'b0;
				end
				default: tmp_q <= tmp_q;
			endcase
		end
		unique case (cmd.op)
			OP_CHECK: begin
				na_q <= $unsigned(a_q);
				nb_q <= $unsigned(b_q);
				ka_q <= '0;
				kb_q <= '0;
			end
			OP_NORM: begin
				if (na_q[63:60] == 4'd0) begin
					na_q <= na_q << 2;
					ka_q <= ka_q + 6'd2;
				end
				if (nb_q[63:60] == 4'd0) begin
					nb_q <= nb_q << 2;
					kb_q <= kb_q + 6'd2;
				end
			end
			OP_SQRT_INIT: begin
				va_q  <= na_q;
				vb_q  <= nb_q;
				ra_q  <= '0;
				rb_q  <= '0;
				bit_q <= 64'h4000_0000_0000_0000;
			end
			OP_SQRT_STEP: begin
				va_q  <= sa_ge ? va_q - sa_try : va_q;
				ra_q  <= sa_ge ? (ra_q >> 1) + bit_q : ra_q >> 1;
				vb_q  <= sb_ge ? vb_q - sb_try : vb_q;
				rb_q  <= sb_ge ? (rb_q >> 1) + bit_q : rb_q >> 1;
				bit_q <= bit_q >> 2;
			end
			OP_DIV1_STEP: begin
				cm_q   <= cm_q << 1;
				rem1_q <= ge1 ? rem1_sh - d_q : rem1_sh;
				q1_q   <= (q1_next > 22'(QCAP)) ? QCAP : q1_next[20:0];
			end
			OP_DIV2_STEP: begin
				num_q  <= num_q << 1;
				rem2_q <= ge2 ? rem2_sh - dv_q : rem2_sh;
				if (fq_next[32]) begin
					fq_q  <= '1;
					sat_q <= 1'b1;
				end else begin
					fq_q <= fq_next[31:0];
				end
			end
			OP_FINISH: begin
				if (is_degen) begin
					fit_q  <= FIT_DEGEN;
					corr_q <= '0;
					deg_q  <= 1'b1;
					satf_q <= 1'b0;
				end else begin
					fit_q  <= fq_q;
					corr_q <= c_q[63] ? -$signed(CORR_W'(rmag)) : $signed(CORR_W'(rmag));
					deg_q  <= 1'b0;
					satf_q <= sat_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_FINISH) begin
			out_valid_q <= 1'b1;
		end else if (out_accept) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.mul_done   = mul_done;
	assign stat.degen      = is_degen;
	assign stat.norm_done  = (na_q[63:60] != 4'd0) && (nb_q[63:60] != 4'd0);
	assign stat.half_shift = half;
	assign stat.out_busy   = out_valid_q;

	assign out_valid   = out_valid_q;
	assign fitness     = fit_q;
	assign correlation = corr_q;
	assign degenerate  = deg_q;
	assign saturated   = satf_q;
endmodule

FILE: rtl/core/cfs_ctrl.sv
// Controller: sequences the end-of-series computation over the datapath.
`timescale 1ns / 1ps
module cfs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               series_end,
	input  cfs_pkg::dp_stat_t  stat,
	output cfs_pkg::dp_cmd_t   cmd,
	output logic               accepting
);
	import cfs_pkg::*;

	ctl_state_t state_q, state_n;
	mul_sel_t   sel_q, sel_n;
	logic [7:0] cnt_q, cnt_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_ACC;
			sel_q   <= MS_NSXX;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			sel_q   <= sel_n;
			cnt_q   <= cnt_n;
		end
	end

	always_comb begin
		state_n = state_q;
		sel_n   = sel_q;
		cnt_n   = cnt_q;
		cmd.op  = OP_NONE;
		cmd.sel = sel_q;
		unique case (state_q)
			S_ACC: begin
				if (series_end) begin
					sel_n   = MS_NSXX;
					state_n = S_MUL_START;
				end
			end
			S_MUL_START: begin
				cmd.op  = OP_MUL_START;
				state_n = S_MUL_WAIT;
			end
			S_MUL_WAIT: begin
				if (stat.mul_done) begin
					cnt_n = '0;
					unique case (sel_q)
						MS_SXSY: state_n = S_CHECK;
						MS_D:    state_n = S_DIV1;
						MS_DV:   state_n = S_DIV2;
						default: begin
							sel_n   = mul_sel_t'(4'(sel_q) + 4'd1);
							state_n = S_MUL_START;
						end
					endcase
				end
			end
			S_CHECK: begin
				cmd.op  = OP_CHECK;
				state_n = stat.degen ? S_FINISH : S_NORM;
			end
			S_NORM: begin
				if (stat.norm_done) begin
					cmd.op  = OP_SQRT_INIT;
					cnt_n   = '0;
					state_n = S_SQRT;
				end else begin
					cmd.op = OP_NORM;
				end
			end
			S_SQRT: begin
				cmd.op = OP_SQRT_STEP;
				cnt_n  = cnt_q + 8'd1;
				if (cnt_q == 8'(SQRT_STEPS - 1)) begin
					sel_n   = MS_D;
					state_n = S_MUL_START;
				end
			end
			S_DIV1: begin
				cmd.op = OP_DIV1_STEP;
				cnt_n  = cnt_q + 8'd1;
				if (cnt_q == 8'(stat.half_shift) + 8'(DIV1_BASE - 1)) begin
					sel_n   = MS_N2;
					state_n = S_MUL_START;
				end
			end
			S_DIV2: begin
				cmd.op = OP_DIV2_STEP;
				cnt_n  = cnt_q + 8'd1;
				if (cnt_q == 8'(DIV2_STEPS - 1)) begin
					state_n = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!stat.out_busy) begin
					cmd.op  = OP_FINISH;
					state_n = S_ACC;
				end
			end
			default: state_n = S_ACC;
		endcase
	end

	assign accepting = (state_q == S_ACC);
endmodule

FILE: rtl/core/correlation_fitness_scorer.sv
// Top level of the correlation fitness scorer.
`timescale 1ns / 1ps
// The block takes sample pairs on the sample channel (x_sample, y_sample, last) and
// returns one score on the result channel for every series, that is on each transfer
// whose last bit is set. While a series is being collected, one pair is accepted
// every cycle and folded into the running sums of x, y, x*x, y*y and x*y; pairs beyond
// 1024 in one series are not summed, but their last bit still closes the series.
// After the closing transfer the sample channel drops ready while the end-of-series
// computation runs: twelve products on a one-bit-per-cycle multiplier, a normalizing
// pass of two-bit shifts, 32 square-root steps done on both deviations together, up
// to 138 steps of the correlation divider (78 plus half of both normalizing shifts)
// and 128 steps of the fitness divider. The shared multiplier dominates. A degenerate
// series stops after six products; any other series runs the whole sequence before
// the result is registered and ready rises again.
// The result sits in an output register; the scorer goes on collecting the next
// series while the receiver stalls, and only waits at the end of that next series
// if the previous result still has not been taken.
// Reset clears the sums, the count and result valid, and raises sample ready; there is no clearing pass.
module correlation_fitness_scorer (
	input  logic       clk,
	input  logic       arst_n,
	cfs_in_if.sink     sample,
	cfs_out_if.source  result
);
	import cfs_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     accepting;
	logic     in_accept;
	logic     out_accept;

	// A transfer on either channel is a cycle with valid and ready both high.
	assign in_accept  = sample.valid && accepting;
	assign out_accept = result.valid && result.ready;
	assign sample.ready = accepting;

	cfs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.series_end (in_accept && sample.last),
		.stat       (stat),
		.cmd        (cmd),
		.accepting  (accepting)
	);

	cfs_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_accept   (in_accept),
		.x_sample    (sample.x_sample),
		.y_sample    (sample.y_sample),
		.out_accept  (out_accept),
		.out_valid   (result.valid),
		.fitness     (result.fitness),
		.correlation (result.correlation),
		.degenerate  (result.degenerate),
		.saturated   (result.saturated)
	);
endmodule

FILE: rtl/core/cfs_checker.sv
// Port-level checks of the correlation fitness scorer and their bind.
`timescale 1ns / 1ps
module cfs_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               in_last,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [cfs_pkg::FIT_W-1:0]          fitness,
	input logic signed [cfs_pkg::CORR_W-1:0]  correlation,
	input logic                               degenerate,
	input logic                               saturated
);
	import cfs_pkg::*;

	// Closing a series starts the computation, so the sample side must stall.
	a_stall_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_last) |=> !in_ready)
		else $error("sample channel still ready after the closing transfer");

	a_degen_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && degenerate) |->
		(fitness == FIT_DEGEN && correlation == 16'sd0 && !saturated))
		else $error("degenerate result has wrong fields");

	a_sat_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && saturated) |-> (fitness == 32'hFFFF_FFFF && !degenerate))
		else $error("saturated result is not clamped");

	a_corr_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (correlation >= -16'sd16384 && correlation <= 16'sd16384))
		else $error("correlation out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(fitness) && $stable(correlation)))
		else $error("stalled result changed");
endmodule

bind correlation_fitness_scorer cfs_checker u_cfs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (sample.valid),
	.in_ready    (sample.ready),
	.in_last     (sample.last),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.fitness     (result.fitness),
	.correlation (result.correlation),
	.degenerate  (result.degenerate),
	.saturated   (result.saturated)
);

FILE: bench/testbench.sv
// Self-checking testbench of the correlation fitness scorer.
`timescale 1ns / 1ps
module testbench;
	import cfs_pkg::*;

	// Timeout in clock cycles. A series costs its length plus its end-of-series work,
	// and a stalled receiver can hold each result for a while. That leaves this
	// limit several times over the slowest correct run.
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam longint unsigned NORM_FLOOR = 64'h1000_0000_0000_0000;
	localparam logic [20:0] CORR_CAP = 21'h10_0000;

	// Kinds of series content used by the random part.
	typedef enum int {
		SER_NOISE,
		SER_FOLLOW,
		SER_MIRROR,
		SER_TINY,
		SER_FLAT
	} series_kind_t;

	typedef struct {
		logic [FIT_W-1:0]         fitness;
		logic signed [CORR_W-1:0] correlation;
		logic                     degenerate;
		logic                     saturated;
	} score_t;

	logic clk;
	logic arst_n;

	cfs_in_if  sample ();
	cfs_out_if result ();

	correlation_fitness_scorer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.result (result)
	);

	// Predictor state: the running sums of the series being collected.
	longint sum_x;
	longint sum_y;
	longint sum_xx;
	longint sum_yy;
	longint sum_xy;
	int     pair_count;

	score_t scores_due[$];
	int     pairs_taken;
	int     errors;
	int     cycles;

	// Idle and stall rates in percent, and the length of a forced receiver hold-off.
	int sender_idle_pct;
	int receiver_stall_pct;
	int hold_off_cycles;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Integer square root of a 64-bit value, one result bit at a time.
	function automatic longint unsigned root_of(input longint unsigned v);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v) begin
				r = t;
			end
		end
		return r;
	endfunction

	// Works out the score of the series held in the predictor sums.
	function automatic score_t series_score();
		score_t s;
		longint n;
		longint dev_x;
		longint dev_y;
		longint co;
		longint unsigned a;
		longint unsigned b;
		longint unsigned d;
		longint unsigned cmag;
		longint unsigned rmag;
		longint unsigned m;
		longint unsigned den;
		longint unsigned p;
		longint unsigned rem;
		longint unsigned q;
		logic bitv;
		int total;
		int ka;
		int kb;
		logic [191:0] wn;
		logic [191:0] wd;
		logic [191:0] wq;
		n = pair_count;
		dev_x = n * sum_xx - sum_x * sum_x;
		dev_y = n * sum_yy - sum_y * sum_y;
		co = n * sum_xy - sum_x * sum_y;
		if (dev_x <= 0 || dev_y <= 0) begin
			s.fitness = FIT_DEGEN;
			s.correlation = '0;
			s.degenerate = 1'b1;
			s.saturated = 1'b0;
			return s;
		end
		// Normalize both deviation sums by even shifts so the square roots keep
		// their precision; the half shift is put back into the dividend.
		a = dev_x;
		b = dev_y;
		ka = 0;
		kb = 0;
		while (a < NORM_FLOOR) begin
			a = a << 2;
			ka += 2;
		end
		while (b < NORM_FLOOR) begin
			b = b << 2;
			kb += 2;
		end
		d = root_of(a) * root_of(b);
		cmag = co < 0 ? -co : co;
		// Restoring division with a 64-bit remainder whose top bit falls off
		// on the shift, and the quotient held at its cap.
		rem = 0;
		q = 0;
		total = 78 + (ka + kb) / 2;
		for (int i = 0; i < total; i++) begin
			bitv = 1'b0;
			if (i < 63) begin
				bitv = cmag[62 - i];
			end
			rem = {rem[62:0], bitv};
			q = q << 1;
			if (rem >= d) begin
				rem = rem - d;
				q = q | 64'd1;
			end
			if (q > 64'(CORR_CAP)) begin
				q = 64'(CORR_CAP);
			end
		end
		rmag = (q + 1) >> 1;
		if (rmag > 64'(R_ONE)) begin
			rmag = 64'(R_ONE);
		end
		s.correlation = co < 0 ? -16'(rmag) : 16'(rmag);
		// Fitness in Q16.16: 0.9 * (1 - |r|), times 0.01 for a positive r,
		// over the product of the two population variances.
		m = 64'(R_ONE) - rmag;
		den = co > 0 ? 64'(DEN_POS) : 64'(DEN_NEG);
		p = 9 * m * n * n * n * n;
		wn = 192'(p) << 50;
		wd = 192'(den * dev_x) * 192'(dev_y);
		wq = wn / wd;
		s.degenerate = 1'b0;
		if (wq > 192'(32'hFFFF_FFFF)) begin
			s.fitness = 32'hFFFF_FFFF;
			s.saturated = 1'b1;
		end else begin
			s.fitness = wq[31:0];
			s.saturated = 1'b0;
		end
		return s;
	endfunction

	// Folds one accepted pair into the sums and, at the end of a series,
	// queues the score that the block owes.
	function automatic void take_pair(input logic [15:0] x, input logic [15:0] y,
		input logic last);
		longint sx;
		longint sy;
		sx = longint'(signed'(x));
		sy = longint'(signed'(y));
		if (pair_count < MAX_SAMPLES) begin
			sum_x += sx;
			sum_y += sy;
			sum_xx += sx * sx;
			sum_yy += sy * sy;
			sum_xy += sx * sy;
			pair_count++;
		end
		if (last) begin
			scores_due.push_back(series_score());
			sum_x = 0;
			sum_y = 0;
			sum_xx = 0;
			sum_yy = 0;
			sum_xy = 0;
			pair_count = 0;
		end
	endfunction

	// Offers one pair, with random idle cycles first, and waits for its transfer.
	// Valid stays high after the transfer; the next call lowers it only for idle cycles, and the end lowers it.
	task automatic send_pair(input logic [15:0] x, input logic [15:0] y, input logic last);
		while ($urandom_range(99) < sender_idle_pct) begin
			sample.valid <= 1'b0;
			@(posedge clk);
		end
		sample.valid <= 1'b1;
		sample.x_sample <= x;
		sample.y_sample <= y;
		sample.last <= last;
		do begin
			@(posedge clk);
		end while (!sample.ready);
		take_pair(x, y, last);
		pairs_taken++;
	endtask

	// Sends one series of the given length and kind of content.
	task automatic send_series(input int len, input series_kind_t kind);
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] noise;
		for (int i = 0; i < len; i++) begin
			x = 16'($urandom);
			noise = 16'($urandom_range(63)) - 16'd32;
			case (kind)
				SER_NOISE: begin
					y = 16'($urandom);
				end
				SER_FOLLOW: begin
					x = {{2{x[15]}}, x[15:2]};
					y = x + noise;
				end
				SER_MIRROR: begin
					x = {{2{x[15]}}, x[15:2]};
					y = noise - x;
				end
				SER_TINY: begin
					x = 16'($urandom_range(7)) - 16'd4;
					y = 16'($urandom_range(7)) - 16'd4;
				end
				default: begin
					y = 16'h0C00;
				end
			endcase
			send_pair(x, y, i == len - 1);
		end
	endtask

	// Hand-picked series: field extremes and every special case of the scorer.
	task automatic test_directed();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		// A series of a single pair has no spread and is degenerate.
		send_pair(16'h7FFF, 16'h8000, 1'b1);
		// Constant x with varying y is degenerate too.
		send_pair(16'h1234, 16'h0001, 1'b0);
		send_pair(16'h1234, 16'hFFFF, 1'b1);
		// Extremes moving against each other: correlation of minus one.
		send_pair(16'h7FFF, 16'h8000, 1'b0);
		send_pair(16'h8000, 16'h7FFF, 1'b0);
		send_pair(16'h7FFF, 16'h8000, 1'b1);
		// Extremes moving together: correlation of plus one, zero fitness.
		send_pair(16'h8000, 16'h8000, 1'b0);
		send_pair(16'h7FFF, 16'h7FFF, 1'b1);
		// Tiny variances: a perfect anticorrelation, then a fitness pushed past its range.
		send_pair(16'h0000, 16'h0001, 1'b0);
		send_pair(16'h0001, 16'h0000, 1'b1);
		send_pair(16'h0000, 16'h0000, 1'b0);
		send_pair(16'h0001, 16'h0001, 1'b0);
		send_pair(16'h0001, 16'h0000, 1'b1);
		// Uncorrelated spread of mixed bit patterns.
		send_pair(16'h5555, 16'hAAAA, 1'b0);
		send_pair(16'hAAAA, 16'hAAAA, 1'b0);
		send_pair(16'h5555, 16'h5555, 1'b0);
		send_pair(16'hAAAA, 16'h5555, 1'b1);
	endtask

	// A series longer than the block holds: pairs past the limit are dropped,
	// and the last mark on a dropped pair still closes the series.
	task automatic test_overlong_series();
		sender_idle_pct = 10;
		receiver_stall_pct = 10;
		send_series(MAX_SAMPLES + 6, SER_FOLLOW);
	endtask

	// Random series in four idling phases: none, sender idle, receiver stalling, both.
	task automatic test_random_series();
		int target;
		int len;
		series_kind_t kind;
		for (int phase = 0; phase < 4; phase++) begin
			sender_idle_pct = (phase == 1) ? 50 : (phase == 3) ? 32 : 0;
			receiver_stall_pct = (phase == 2) ? 50 : (phase == 3) ? 32 : 0;
			target = pairs_taken + 80;
			while (pairs_taken < target) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(200, 40) : $urandom_range(30, 1);
				kind = series_kind_t'($urandom_range(4));
				send_series(len, kind);
			end
		end
	endtask

	// The receiver holds off for a long stretch while three series go in, so
	// the block keeps one score waiting and stalls the sample channel.
	task automatic test_result_backpressure();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hold_off_cycles = 5000;
		for (int i = 0; i < 3; i++) begin
			send_series(12, SER_NOISE);
		end
	endtask

	// Result side: random stalls or a forced hold-off, and the check of each transfer.
	always @(posedge clk) begin
		score_t want;
		if (arst_n && result.valid && result.ready) begin
			if (scores_due.size() == 0) begin
				$display("%0t: score with none expected: fitness %h correlation %0d",
					$time, result.fitness, result.correlation);
				errors++;
			end else begin
				want = scores_due.pop_front();
				if (result.fitness !== want.fitness) begin
					$display("%0t: fitness expected %h actual %h", $time, want.fitness,
						result.fitness);
					errors++;
				end
				if (result.correlation !== want.correlation) begin
					$display("%0t: correlation expected %0d actual %0d", $time,
						want.correlation, result.correlation);
					errors++;
				end
				if (result.degenerate !== want.degenerate) begin
					$display("%0t: degenerate expected %b actual %b", $time,
						want.degenerate, result.degenerate);
					errors++;
				end
				if (result.saturated !== want.saturated) begin
					$display("%0t: saturated expected %b actual %b", $time,
						want.saturated, result.saturated);
					errors++;
				end
			end
		end
		if (hold_off_cycles > 0) begin
			hold_off_cycles--;
			result.ready <= 1'b0;
		end else begin
			result.ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	// Timeout watch.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		sample.valid = 1'b0;
		sample.x_sample = '0;
		sample.y_sample = '0;
		sample.last = 1'b0;
		result.ready = 1'b0;
		sum_x = 0;
		sum_y = 0;
		sum_xx = 0;
		sum_yy = 0;
		sum_xy = 0;
		pair_count = 0;
		pairs_taken = 0;
		errors = 0;
		cycles = 0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hold_off_cycles = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_overlong_series();
		test_random_series();
		test_result_backpressure();

		sample.valid <= 1'b0;
		receiver_stall_pct = 0;
		while (scores_due.size() != 0) begin
			@(posedge clk);
		end
		// Give a stray late score time to show up.
		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/cfs_pkg.sv
rtl/core/cfs_in_if.sv
rtl/core/cfs_out_if.sv
rtl/core/cfs_mul.sv
rtl/core/cfs_datapath.sv
rtl/core/cfs_ctrl.sv
rtl/core/correlation_fitness_scorer.sv
rtl/core/cfs_checker.sv
bench/testbench.sv
